### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the CSV field splitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the CSV field splitter modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

    // Width of a decoded character code point.
    localparam int CODE_W = 21;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Special characters.
    localparam logic [CODE_W-1:0] CH_BACKSLASH = 21'h0005C;
    localparam logic [CODE_W-1:0] CH_QUOTE     = 21'h00022;
    localparam logic [CODE_W-1:0] CH_SPACE     = 21'h00020;
    localparam logic [CODE_W-1:0] SEP_RESET    = 21'h0002C;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_UNQUOTED = 3'd0,
        MODE_QUOTED   = 3'd1,
        MODE_ESCAPE   = 3'd2,
        MODE_AFTER    = 3'd3,
        MODE_DISCARD  = 3'd4
    } mode_t;

    // Kinds of event on the result channel.
    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_FIELD = 2'd1,
        EV_LINE  = 2'd2,
        EV_ERROR = 2'd3
    } ev_kind_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_ESCAPE = 2'd1,
        ERR_SEP    = 2'd2
    } err_code_t;

    // A classified request as held in the queue.
    typedef struct packed {
        logic              eol;
        logic              is_space;
        logic              is_bslash;
        logic              is_quote;
        logic              is_sep;
        logic [CODE_W-1:0] ch;
    } item_t;

endpackage

### sv/cfp_if.sv
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channel interfaces for characters, events and configuration.
// ----------------------------------------------------------------------------

// Incoming decoded characters and end-of-line markers.
interface cfp_char_if import cfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] char_code;
    logic              end_of_line;

    modport source (output valid, char_code, end_of_line, input ready);
    modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

// Outgoing parse events.
interface cfp_event_if import cfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [CODE_W-1:0] out_char;
    logic [1:0]        error_code;

    modport source (output valid, event_kind, out_char, error_code, input ready);
    modport sink   (input valid, event_kind, out_char, error_code, output ready);
endinterface

// Separator register write channel.
interface cfp_cfg_if import cfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### sv/csv_line_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_line_field_splitter: splits decoded characters into CSV field events.
// Path: an accepted character reaches its event through a queue slot and the output register.
// Throughput: one character per cycle, bound by the mode loop, unless event_out stalls.
// Reset: rst_n clears the mode to unquoted, empties the queue and sets the separator to comma.
// ----------------------------------------------------------------------------
module csv_line_field_splitter import cfp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cfp_char_if.sink    char_in,
    cfp_cfg_if.sink     cfg,
    cfp_event_if.source event_out
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    item_t push_item;
    item_t head;

    // Front: accepts and classifies requests.
    cfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // Queue between front and back.
    cfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: mode machine and output register.
    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .event_out (event_out)
    );

endmodule

### sv/cfp_front.sv
// ----------------------------------------------------------------------------
// cfp_front
// Accepts character requests, classifies them and pushes them to the queue.
// ----------------------------------------------------------------------------
module cfp_front import cfp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cfp_char_if.sink    char_in,
    cfp_cfg_if.sink     cfg,
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    logic [CODE_W-1:0] sep_reg;

    // The separator register takes every write at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= SEP_RESET;
        end
        else if (cfg.valid)
        begin
            sep_reg <= cfg.data;
        end
    end

    // A request is taken whenever the queue has room.
    assign char_in.ready = !q_full;
    assign push          = char_in.valid && !q_full;

    // Classify the character against the special codes.
    always_comb
    begin
        push_item.eol       = char_in.end_of_line;
        push_item.is_space  = (char_in.char_code == CH_SPACE);
        push_item.is_bslash = (char_in.char_code == CH_BACKSLASH);
        push_item.is_quote  = (char_in.char_code == CH_QUOTE);
        push_item.is_sep    = (char_in.char_code == sep_reg);
        push_item.ch        = char_in.char_code;
    end

endmodule

### sv/cfp_queue.sv
// ----------------------------------------------------------------------------
// cfp_queue
// Small first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfp_queue import cfp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    // Pointers wrap at the depth, the count follows pushes and pops.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from an empty queue")
    `ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into a full queue")
    `ASSERT_CLK(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

### sv/cfp_back.sv
// ----------------------------------------------------------------------------
// cfp_back
// Runs the quote and escape mode machine and registers the resulting events.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfp_back import cfp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       head,
    input  logic        q_empty,
    output logic        pop,
    cfp_event_if.source event_out
);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic              out_valid_reg;
    ev_kind_t          kind_reg;
    logic [CODE_W-1:0] char_reg;
    err_code_t         err_reg;
    logic              emit;
    ev_kind_t          kind_next;
    logic [CODE_W-1:0] char_next;
    err_code_t         err_next;

    // Take the next request once the output register is free or draining.
    assign pop = !q_empty && (!out_valid_reg || event_out.ready);

    // Mode machine: next mode and the event that the request causes.
    always_comb
    begin
        mode_next = mode_reg;
        emit      = 1'b0;
        kind_next = EV_CHAR;
        char_next = '0;
        err_next  = ERR_NONE;
        if (pop)
        begin
            if (head.eol)
            begin
                mode_next = MODE_UNQUOTED;
                if (mode_reg == MODE_ESCAPE)
                begin
                    emit      = 1'b1;
                    kind_next = EV_ERROR;
                    err_next  = ERR_ESCAPE;
                end
                else if (mode_reg != MODE_DISCARD)
                begin
                    emit      = 1'b1;
                    kind_next = EV_LINE;
                end
            end
            else
            begin
                unique case (mode_reg)
                    MODE_QUOTED:
                    begin
                        if (head.is_bslash)
                        begin
                            mode_next = MODE_ESCAPE;
                        end
                        else if (head.is_quote)
                        begin
                            mode_next = MODE_AFTER;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            char_next = head.ch;
                        end
                    end
                    MODE_ESCAPE:
                    begin
                        emit = 1'b1;
                        if (head.is_quote)
                        begin
                            mode_next = MODE_QUOTED;
                            char_next = head.ch;
                        end
                        else
                        begin
                            mode_next = MODE_DISCARD;
                            kind_next = EV_ERROR;
                            err_next  = ERR_ESCAPE;
                        end
                    end
                    MODE_AFTER:
                    begin
                        if (!head.is_space)
                        begin
                            emit = 1'b1;
                            if (head.is_sep)
                            begin
                                mode_next = MODE_UNQUOTED;
                                kind_next = EV_FIELD;
                            end
                            else
                            begin
                                mode_next = MODE_DISCARD;
                                kind_next = EV_ERROR;
                                err_next  = ERR_SEP;
                            end
                        end
                    end
                    MODE_DISCARD:
                    begin
                        mode_next = MODE_DISCARD;
                    end
                    default:
                    begin
                        // Unquoted: space, backslash, quote, separator in that order.
                        mode_next = MODE_UNQUOTED;
                        if (head.is_space)
                        begin
                            emit = 1'b0;
                        end
                        else if (head.is_bslash)
                        begin
                            emit      = 1'b1;
                            char_next = head.ch;
                        end
                        else if (head.is_quote)
                        begin
                            mode_next = MODE_QUOTED;
                        end
                        else if (head.is_sep)
                        begin
                            emit      = 1'b1;
                            kind_next = EV_FIELD;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            char_next = head.ch;
                        end
                    end
                endcase
            end
        end
    end

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNQUOTED;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (event_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            char_reg <= char_next;
            err_reg  <= err_next;
        end
    end

    assign event_out.valid      = out_valid_reg;
    assign event_out.event_kind = kind_reg;
    assign event_out.out_char   = char_reg;
    assign event_out.error_code = err_reg;

    `ASSERT_CLK(a_err_code, clk, rst_n, out_valid_reg |-> ((kind_reg == EV_ERROR) == (err_reg != ERR_NONE)), "error code does not match event kind")
    `ASSERT_CLK(a_eol_mode, clk, rst_n, (pop && head.eol) |=> (mode_reg == MODE_UNQUOTED), "end of line left a mode set")
    `ASSERT_CLK(a_err_discard, clk, rst_n, (emit && !head.eol && kind_next == EV_ERROR) |=> (mode_reg == MODE_DISCARD), "error did not start discarding")

endmodule
